/* rtl/i2cm_pkg.sv */
package i2cm_pkg;

  localparam int unsigned BufferDepth     = 256;
  localparam int unsigned BusCountDefault = 10;

  localparam logic [15:0] HalfPeriodReset  = 16'd2;
  localparam logic [7:0]  AckTimeoutReset  = 8'd25;

  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_LOAD = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PROBE = 2'd2,
    OP_BAD   = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CFG_HALF_PERIOD = 1'b0,
    CFG_ACK_TIMEOUT = 1'b1
  } cfg_e;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_START    = 5'd1,
    PH_RESTART  = 5'd2,
    PH_TX_DEV   = 5'd3,
    PH_ACK_DEV  = 5'd4,
    PH_TX_REGHI = 5'd5,
    PH_ACK_REGHI= 5'd6,
    PH_TX_REGLO = 5'd7,
    PH_ACK_REGLO= 5'd8,
    PH_TX_DATA  = 5'd9,
    PH_ACK_DATA = 5'd10,
    PH_TX_DEVR  = 5'd11,
    PH_ACK_DEVR = 5'd12,
    PH_RX_BITS  = 5'd13,
    PH_RX_ACK   = 5'd14,
    PH_MIDSTOP  = 5'd15,
    PH_STOP     = 5'd16
  } phase_e;

  // item as classified by the front end
  typedef struct packed {
    kind_e       kind;
    logic        cmd_ok;
    op_e         op;
    logic [3:0]  bus;
    logic [7:0]  dev;
    logic [15:0] regaddr;
    logic        two;
    logic [7:0]  count;
    logic [7:0]  wbyte;
    logic        sda;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       en;
    logic [3:0] bus;
    logic [7:0] rdata;
    logic       rvalid;
    logic       rlast;
    logic       missing;
    logic       present;
    logic       busy;
    logic       done;
  } res_t;

endpackage

/* rtl/i2cm_ram.sv */
module i2cm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/i2cm_front.sv */
module i2cm_front #(
  parameter int unsigned BusCount = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  bus_select_i,
  input  logic [7:0]  device_address_i,
  input  logic [15:0] register_address_i,
  input  logic        register_two_bytes_i,
  input  logic [7:0]  transfer_count_i,
  input  logic [7:0]  write_byte_i,
  input  logic        sda_sample_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output i2cm_pkg::item_t q_item_o
);
  import i2cm_pkg::*;

  // two-entry queue
  item_t  mem_q [2];
  logic   wp_q, rp_q;
  logic [1:0] cnt_q;
  item_t  it;
  logic   push, pop;

  always_comb begin
    it.kind    = kind_e'(kind_i);
    it.op      = op_e'(operation_i);
    it.cmd_ok  = (operation_i != OP_BAD) && ({28'd0, bus_select_i} < 32'(BusCount));
    it.bus     = bus_select_i;
    it.dev     = device_address_i;
    it.regaddr = register_address_i;
    it.two     = register_two_bytes_i;
    it.count   = transfer_count_i;
    it.wbyte   = write_byte_i;
    it.sda     = sda_sample_i;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= it;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1)) else $error("count not advanced");
endmodule

/* rtl/i2cm_back.sv */
module i2cm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i,
  input  logic            cfg_index_i,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  i2cm_pkg::item_t q_item_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output i2cm_pkg::res_t  res_o
);
  import i2cm_pkg::*;

  localparam int unsigned Aw = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;

  logic [15:0] hp_q;
  logic [7:0]  to_q;
  phase_e      ph_q, ph_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  byte_q, byte_d, sh_q, sh_d, wait_q, wait_d, lp_q, lp_d;
  logic [15:0] tick_q, tick_d;
  op_e         op_q, op_d;
  logic [3:0]  bus_q, bus_d;
  logic [7:0]  dev_q, dev_d, cnt_q, cnt_d;
  logic [15:0] reg_q, reg_d;
  logic        two_q, two_d, pa_q, pa_d;
  logic        scl_q, scl_d, sda_q, sda_d, en_q, en_d;

  logic        ov_q;      // output register valid
  res_t        out_q, out_d;
  logic        take;
  logic        fetch_q;   // a data byte read is in flight from the buffer
  logic [7:0]  rd_data;
  logic        we;
  logic [Aw-1:0] raddr;

  // the buffer read is registered; the entering of a data byte needs it
  logic        need_fetch;
  logic [7:0]  fetch_idx;

  assign q_ready_o   = (!ov_q || res_ready_i) && !fetch_q;
  assign take        = q_valid_i && q_ready_o;
  assign res_valid_o = ov_q;
  assign res_o       = out_q;

  assign we = take && (q_item_i.kind == KIND_LOAD) && (ph_q == PH_IDLE);

  i2cm_ram #(.Width(8), .Depth(BufferDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (lp_q[Aw-1:0]),
    .wdata_i (q_item_i.wbyte),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  always_comb begin
    logic [15:0] hp;
    logic        hi, txack, ack_now, last;
    logic [2:0]  role;
    logic [7:0]  byte_inc;
    logic [15:0] tick_inc;
    phase_e      nph;
    logic [3:0]  nb;
    logic        do_enter;
    logic        rv, rl, miss, dn;
    logic [7:0]  rdat;
    logic        adv_ack;
    logic [2:0]  next_role;
    logic        go_tx;

    ph_d = ph_q; bit_d = bit_q; byte_d = byte_q; sh_d = sh_q; wait_d = wait_q;
    lp_d = lp_q; tick_d = tick_q; op_d = op_q; bus_d = bus_q; dev_d = dev_q;
    cnt_d = cnt_q; reg_d = reg_q; two_d = two_q; pa_d = pa_q;
    scl_d = scl_q; sda_d = sda_q; en_d = en_q;
    need_fetch = 1'b0; fetch_idx = byte_q;
    rv = 1'b0; rl = 1'b0; miss = 1'b0; dn = 1'b0; rdat = 8'd0;
    nph = ph_q; nb = 4'd0; do_enter = 1'b0; adv_ack = 1'b0;
    next_role = 3'd0; go_tx = 1'b0;

    hp       = (hp_q == 16'd0) ? 16'd1 : hp_q;
    hi       = bit_q[0];
    txack    = (ph_q >= PH_TX_DEV) && (ph_q < PH_RX_BITS) && !ph_q[0];
    role     = 3'((ph_q - PH_TX_DEV) >> 1);
    byte_inc = byte_q + 8'd1;
    tick_inc = tick_q + 16'd1;
    last     = ({1'b0, byte_q} + 9'd1) >= {1'b0, cnt_q};
    ack_now  = 1'b0;

    if (take) begin
      unique case (q_item_i.kind)
        KIND_CMD: begin
          if (ph_q == PH_IDLE && q_item_i.cmd_ok) begin
            op_d = q_item_i.op; bus_d = q_item_i.bus; dev_d = q_item_i.dev;
            reg_d = q_item_i.regaddr; two_d = q_item_i.two; cnt_d = q_item_i.count;
            pa_d = 1'b0; lp_d = 8'd0; byte_d = 8'd0;
            nph = PH_START; nb = 4'd0; do_enter = 1'b1;
          end
        end
        KIND_LOAD: begin
          if (ph_q == PH_IDLE) lp_d = lp_q + 8'd1;
        end
        KIND_TICK: begin
          if (ph_q != PH_IDLE) begin
            if (txack && bit_q == 4'd1) begin
              if (!q_item_i.sda) begin
                if (role == 3'd0 && op_q == OP_PROBE) pa_d = 1'b1;
                adv_ack = 1'b1;
              end else if (wait_q >= to_q) begin
                miss = 1'b1; adv_ack = 1'b1;
              end else begin
                wait_d = wait_q + 8'd1;
              end
            end else begin
              tick_d = tick_inc;
              if (tick_inc >= hp) begin
                ack_now = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (adv_ack) begin
      unique case (role)
        3'd0: begin
          if (op_q == OP_PROBE) begin nph = PH_STOP; do_enter = 1'b1; end
          else begin go_tx = 1'b1; next_role = two_q ? 3'd1 : 3'd2; end
        end
        3'd1: begin go_tx = 1'b1; next_role = 3'd2; end
        3'd2: begin
          byte_d = 8'd0;
          if (op_q == OP_READ) begin nph = PH_MIDSTOP; do_enter = 1'b1; end
          else if (cnt_q != 8'd0) begin
            go_tx = 1'b1; next_role = 3'd3; fetch_idx = 8'd0;
          end else begin nph = PH_STOP; do_enter = 1'b1; end
        end
        3'd3: begin
          byte_d = byte_inc;
          if (byte_inc < cnt_q) begin go_tx = 1'b1; next_role = 3'd3; fetch_idx = byte_inc; end
          else begin nph = PH_STOP; do_enter = 1'b1; end
        end
        default: begin
          byte_d = 8'd0; sh_d = 8'd0;
          nph = (cnt_q != 8'd0) ? PH_RX_BITS : PH_STOP; do_enter = 1'b1;
        end
      endcase
    end

    if (ack_now) begin
      priority if (ph_q == PH_START || ph_q == PH_RESTART) begin
        if (bit_q == 4'd0) begin nph = ph_q; nb = 4'd1; do_enter = 1'b1; end
        else begin go_tx = 1'b1; next_role = (ph_q == PH_START) ? 3'd0 : 3'd4; end
      end else if (txack) begin
        nph = ph_q; nb = 4'd1; do_enter = 1'b1;
      end else if (ph_q >= PH_TX_DEV && ph_q < PH_RX_BITS) begin
        do_enter = 1'b1;
        if (bit_q < 4'd15) begin nph = ph_q; nb = bit_q + 4'd1; end
        else nph = phase_e'(ph_q + 5'd1);
      end else if (ph_q == PH_RX_BITS) begin
        logic [7:0] s;
        s = hi ? {sh_q[6:0], q_item_i.sda} : sh_q;
        sh_d = s;
        do_enter = 1'b1;
        if (bit_q < 4'd15) begin nph = PH_RX_BITS; nb = bit_q + 4'd1; end
        else begin rdat = s; rv = 1'b1; rl = last; nph = PH_RX_ACK; end
      end else if (ph_q == PH_RX_ACK) begin
        do_enter = 1'b1;
        if (bit_q == 4'd0) begin nph = PH_RX_ACK; nb = 4'd1; end
        else begin
          byte_d = byte_inc; sh_d = 8'd0;
          nph = (byte_inc < cnt_q) ? PH_RX_BITS : PH_STOP;
        end
      end else if (ph_q == PH_MIDSTOP) begin
        do_enter = 1'b1;
        if (bit_q < 4'd2) begin nph = PH_MIDSTOP; nb = bit_q + 4'd1; end
        else nph = PH_RESTART;
      end else if (ph_q == PH_STOP) begin
        if (bit_q < 4'd2) begin nph = PH_STOP; nb = bit_q + 4'd1; do_enter = 1'b1; end
        else begin ph_d = PH_IDLE; bit_d = 4'd0; tick_d = 16'd0; dn = 1'b1; end
      end else begin
        ph_d = PH_IDLE;
      end
    end

    if (go_tx) begin
      nph = phase_e'(5'(PH_TX_DEV) + {1'b0, next_role, 1'b0});
      nb = 4'd0; do_enter = 1'b1;
      unique case (next_role)
        3'd0: sh_d = dev_q;
        3'd4: sh_d = dev_q + 8'd1;
        3'd1: sh_d = reg_q[15:8];
        3'd2: sh_d = reg_q[7:0];
        3'd3: need_fetch = 1'b1;  // byte patched in when RAM data returns
        default: sh_d = 8'd0;
      endcase
    end

    if (do_enter) begin
      logic b1;
      ph_d = nph; bit_d = nb; tick_d = 16'd0; wait_d = 8'd0;
      b1 = nb[0];
      if (nph == PH_START || nph == PH_RESTART) begin
        scl_d = 1'b1; sda_d = !b1; en_d = 1'b1;
      end else if (nph >= PH_TX_DEV && nph < PH_RX_BITS) begin
        if (nph[0]) begin scl_d = b1; sda_d = sh_d[3'd7 - 3'(nb >> 1)]; en_d = 1'b1; end
        else begin scl_d = b1; sda_d = 1'b1; en_d = 1'b0; end
      end else if (nph == PH_RX_BITS) begin
        scl_d = b1; sda_d = 1'b1; en_d = 1'b0;
      end else if (nph == PH_RX_ACK) begin
        scl_d = b1; sda_d = ({1'b0, byte_d} + 9'd1) >= {1'b0, cnt_q}; en_d = 1'b1;
      end else begin
        scl_d = (nb >= 4'd1); sda_d = (nb >= 4'd2); en_d = 1'b1;
      end
    end

    out_d.scl = scl_d; out_d.sda = sda_d; out_d.en = en_d; out_d.bus = bus_d;
    out_d.rdata = rdat; out_d.rvalid = rv; out_d.rlast = rl; out_d.missing = miss;
    out_d.present = pa_d; out_d.busy = (ph_d != PH_IDLE); out_d.done = dn;
  end

  assign raddr = fetch_idx[Aw-1:0];

  always_ff @(posedge clk_i) begin
    if (take) out_q <= out_d;
    else if (fetch_q) begin
      out_q.sda <= rd_data[7];  // first data bit, bit counter is zero
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q <= HalfPeriodReset; to_q <= AckTimeoutReset;
      ph_q <= PH_IDLE; bit_q <= '0; byte_q <= '0; sh_q <= '0; wait_q <= '0;
      lp_q <= '0; tick_q <= '0; op_q <= OP_WRITE; bus_q <= '0; dev_q <= '0;
      cnt_q <= '0; reg_q <= '0; two_q <= 1'b0; pa_q <= 1'b0;
      scl_q <= 1'b0; sda_q <= 1'b0; en_q <= 1'b1;
      ov_q <= 1'b0; fetch_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_HALF_PERIOD: hp_q <= cfg_wdata_i;
          CFG_ACK_TIMEOUT: to_q <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (take) begin
        ph_q <= ph_d; bit_q <= bit_d; byte_q <= byte_d; sh_q <= sh_d; wait_q <= wait_d;
        lp_q <= lp_d; tick_q <= tick_d; op_q <= op_d; bus_q <= bus_d; dev_q <= dev_d;
        cnt_q <= cnt_d; reg_q <= reg_d; two_q <= two_d; pa_q <= pa_d;
        scl_q <= scl_d; sda_q <= sda_d; en_q <= en_d;
      end else if (fetch_q) begin
        sh_q  <= rd_data;
        sda_q <= rd_data[7];
      end
      fetch_q <= take && need_fetch;
      // result is held until the fetched byte patches it
      if (take) ov_q <= !need_fetch;
      else if (fetch_q) ov_q <= 1'b1;
      else if (res_ready_i) ov_q <= 1'b0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) fetch_q |-> !ov_q)
    else $error("result shown before buffer byte arrived");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_IDLE) |-> (tick_q == 16'd0 || $past(ph_q) == PH_IDLE))
    else $error("tick counter not cleared at idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_q.rvalid |-> out_q.busy) else $error("read byte outside transfer");
endmodule

/* rtl/i2c_master_register_transfer.sv */
// Items pass the input queue and results the output register; an item that
// starts a write data byte also waits for the write buffer read.
// Throughput: one item per cycle, stalled by out_ready_i and write buffer reads.
// A two-entry input queue separates acceptance from execution.
// Reset (asynchronous, active low): idle, counters cleared, SCL low, SDA low
// driven; the write buffer holds no defined data until loaded.
module i2c_master_register_transfer #(
  parameter int unsigned BusCount = i2cm_pkg::BusCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  bus_select_i,
  input  logic [7:0]  device_address_i,
  input  logic [15:0] register_address_i,
  input  logic        register_two_bytes_i,
  input  logic [7:0]  transfer_count_i,
  input  logic [7:0]  write_byte_i,
  input  logic        sda_sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        clock_line_o,
  output logic        data_line_drive_o,
  output logic        data_line_enable_o,
  output logic [3:0]  bus_index_o,
  output logic [7:0]  read_data_o,
  output logic        read_valid_o,
  output logic        read_last_o,
  output logic        ack_missing_o,
  output logic        device_present_o,
  output logic        busy_res_o,
  output logic        done_res_o
);
  import i2cm_pkg::*;

  item_t q_item;
  logic  q_valid, q_ready;
  res_t  res;

  i2cm_front #(.BusCount(BusCount)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .operation_i, .bus_select_i,
    .device_address_i, .register_address_i, .register_two_bytes_i, .transfer_count_i,
    .write_byte_i, .sda_sample_i,
    .q_valid_o (q_valid), .q_ready_i (q_ready), .q_item_o (q_item)
  );

  i2cm_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .cfg_index_i,
    .q_valid_i (q_valid), .q_ready_o (q_ready), .q_item_i (q_item),
    .res_valid_o (out_valid_o), .res_ready_i (out_ready_i), .res_o (res)
  );

  assign clock_line_o       = res.scl;
  assign data_line_drive_o  = res.sda;
  assign data_line_enable_o = res.en;
  assign bus_index_o        = res.bus;
  assign read_data_o        = res.rdata;
  assign read_valid_o       = res.rvalid;
  assign read_last_o        = res.rlast;
  assign ack_missing_o      = res.missing;
  assign device_present_o   = res.present;
  assign busy_res_o         = res.busy;
  assign done_res_o         = res.done;
endmodule

/* verif/i2c_master_register_transfer_test.sv */
module i2c_master_register_transfer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  localparam int ROLE_DEV   = 0;
  localparam int ROLE_REGHI = 1;
  localparam int ROLE_REGLO = 2;
  localparam int ROLE_DATA  = 3;
  localparam int ROLE_DEVR  = 4;
  localparam int NUM_BUSES  = 10;

  typedef struct {
    kind_e       kind;
    op_e         op;
    logic [3:0]  bus;
    logic [7:0]  dev;
    logic [15:0] regaddr;
    logic        two;
    logic [7:0]  count;
    logic [7:0]  wbyte;
    logic        sda;
  } req_t;

  typedef struct {
    req_t req;
    bit   typed;
    res_t exp;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = '0;
  logic [1:0]  operation_i = '0;
  logic [3:0]  bus_select_i = '0;
  logic [7:0]  device_address_i = '0;
  logic [15:0] register_address_i = '0;
  logic        register_two_bytes_i = 1'b0;
  logic [7:0]  transfer_count_i = '0;
  logic [7:0]  write_byte_i = '0;
  logic        sda_sample_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        clock_line_o, data_line_drive_o, data_line_enable_o;
  logic [3:0]  bus_index_o;
  logic [7:0]  read_data_o;
  logic        read_valid_o, read_last_o, ack_missing_o, device_present_o;
  logic        busy_res_o, done_res_o;

  i2c_master_register_transfer dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // bus controller shadow
  logic [15:0] half_ticks;
  logic [7:0]  ack_limit;
  phase_e      ph;
  logic [3:0]  bit_cnt;
  logic [7:0]  byte_cnt, shreg, ack_wait, load_ptr;
  int          tick_cnt;
  logic [7:0]  wbuf [256];
  bit          wbuf_set [256];
  op_e         act_op;
  logic [3:0]  act_bus;
  logic [7:0]  act_dev, act_count;
  logic [15:0] act_reg;
  logic        act_two, acked, scl, sda, sda_en;

  res_t        expected_q[$];
  int          mismatches = 0;
  bit          failed = 0;
  int          burst_left = 0;

  function automatic void drive_lines();
    int p = int'(ph);
    logic hi = bit_cnt[0];
    if (ph == PH_START || ph == PH_RESTART) begin
      scl = 1; sda = !hi; sda_en = 1;
    end else if (p >= int'(PH_TX_DEV) && p < int'(PH_RX_BITS)) begin
      scl = hi;
      if (((p - int'(PH_TX_DEV)) & 1) == 0) begin
        sda = shreg[7 - (bit_cnt >> 1)]; sda_en = 1;
      end else begin
        sda = 1; sda_en = 0;
      end
    end else if (ph == PH_RX_BITS) begin
      scl = hi; sda = 1; sda_en = 0;
    end else if (ph == PH_RX_ACK) begin
      scl = hi; sda = (int'(byte_cnt) + 1 >= int'(act_count)); sda_en = 1;
    end else if (ph == PH_MIDSTOP || ph == PH_STOP) begin
      scl = (bit_cnt >= 1); sda = (bit_cnt >= 2); sda_en = 1;
    end
  endfunction

  function automatic void go(phase_e p, int b);
    ph = p;
    bit_cnt = 4'(b);
    tick_cnt = 0;
    ack_wait = 0;
    drive_lines();
  endfunction

  function automatic void send_byte(int role);
    case (role)
      ROLE_DEV:   shreg = act_dev;
      ROLE_DEVR:  shreg = act_dev + 8'd1;
      ROLE_REGHI: shreg = act_reg[15:8];
      ROLE_REGLO: shreg = act_reg[7:0];
      default:    shreg = wbuf[byte_cnt];
    endcase
    go(phase_e'(int'(PH_TX_DEV) + 2 * role), 0);
  endfunction

  function automatic void byte_acked(int role);
    case (role)
      ROLE_DEV:
        if (act_op == OP_PROBE) go(PH_STOP, 0);
        else send_byte(act_two ? ROLE_REGHI : ROLE_REGLO);
      ROLE_REGHI: send_byte(ROLE_REGLO);
      ROLE_REGLO: begin
        byte_cnt = 0;
        if (act_op == OP_READ) go(PH_MIDSTOP, 0);
        else if (act_count > 0) send_byte(ROLE_DATA);
        else go(PH_STOP, 0);
      end
      ROLE_DATA: begin
        byte_cnt = byte_cnt + 8'd1;
        if (byte_cnt < act_count) send_byte(ROLE_DATA);
        else go(PH_STOP, 0);
      end
      default: begin
        byte_cnt = 0;
        shreg = 0;
        if (act_count > 0) go(PH_RX_BITS, 0);
        else go(PH_STOP, 0);
      end
    endcase
  endfunction

  function automatic bit in_ack_slot();
    int p = int'(ph);
    return p >= int'(PH_TX_DEV) && p < int'(PH_RX_BITS) && ((p - int'(PH_TX_DEV)) & 1);
  endfunction

  function automatic res_t bus_step(req_t r);
    res_t o = '0;
    int   hp, role;
    if (r.kind == KIND_CMD) begin
      if (ph == PH_IDLE && r.op != OP_BAD && r.bus < NUM_BUSES) begin
        act_op = r.op; act_bus = r.bus; act_dev = r.dev; act_reg = r.regaddr;
        act_two = r.two; act_count = r.count;
        acked = 0; load_ptr = 0; byte_cnt = 0;
        go(PH_START, 0);
      end
    end else if (r.kind == KIND_LOAD) begin
      if (ph == PH_IDLE) begin
        wbuf[load_ptr] = r.wbyte;
        wbuf_set[load_ptr] = 1;
        load_ptr = load_ptr + 8'd1;
      end
    end else if (r.kind == KIND_TICK && ph != PH_IDLE) begin
      hp = (half_ticks == 0) ? 1 : int'(half_ticks);
      role = (int'(ph) - int'(PH_TX_DEV)) >> 1;
      if (in_ack_slot() && bit_cnt == 1) begin
        if (!r.sda) begin
          if (role == ROLE_DEV && act_op == OP_PROBE) acked = 1;
          byte_acked(role);
        end else if (ack_wait >= ack_limit) begin
          o.missing = 1;
          byte_acked(role);
        end else begin
          ack_wait++;
        end
      end else begin
        tick_cnt++;
        if (tick_cnt >= hp) begin
          if (ph == PH_START || ph == PH_RESTART) begin
            if (bit_cnt == 0) go(ph, 1);
            else send_byte(ph == PH_START ? ROLE_DEV : ROLE_DEVR);
          end else if (in_ack_slot()) begin
            go(ph, 1);
          end else if (int'(ph) >= int'(PH_TX_DEV) && int'(ph) < int'(PH_RX_BITS)) begin
            if (bit_cnt < 15) go(ph, bit_cnt + 1);
            else go(phase_e'(int'(ph) + 1), 0);
          end else if (ph == PH_RX_BITS) begin
            if (bit_cnt[0]) shreg = {shreg[6:0], r.sda};
            if (bit_cnt < 15) begin
              go(PH_RX_BITS, bit_cnt + 1);
            end else begin
              o.rdata = shreg;
              o.rvalid = 1;
              o.rlast = (int'(byte_cnt) + 1 >= int'(act_count));
              go(PH_RX_ACK, 0);
            end
          end else if (ph == PH_RX_ACK) begin
            if (bit_cnt == 0) begin
              go(PH_RX_ACK, 1);
            end else begin
              byte_cnt = byte_cnt + 8'd1;
              shreg = 0;
              if (byte_cnt < act_count) go(PH_RX_BITS, 0);
              else go(PH_STOP, 0);
            end
          end else if (ph == PH_MIDSTOP) begin
            if (bit_cnt < 2) go(PH_MIDSTOP, bit_cnt + 1);
            else go(PH_RESTART, 0);
          end else if (ph == PH_STOP) begin
            if (bit_cnt < 2) begin
              go(PH_STOP, bit_cnt + 1);
            end else begin
              ph = PH_IDLE; bit_cnt = 0; tick_cnt = 0;
              o.done = 1;
            end
          end
        end
      end
    end
    o.scl = scl; o.sda = sda; o.en = sda_en; o.bus = act_bus;
    o.present = acked;
    o.busy = (ph != PH_IDLE);
    return o;
  endfunction

  function automatic req_t any_req();
    req_t r;
    r.kind = kind_e'($urandom_range(0, 3));
    r.op = op_e'($urandom_range(0, 3));
    r.bus = 4'($urandom_range(0, 15));
    r.dev = 8'($urandom);
    r.regaddr = 16'($urandom);
    r.two = 1'($urandom);
    r.count = 8'($urandom);
    r.wbyte = 8'($urandom);
    r.sda = 1'($urandom);
    return r;
  endfunction

  task automatic issue(req_t r, bit typed = 0, res_t typed_exp = '0);
    res_t e = bus_step(r);
    expected_q.push_back(typed ? typed_exp : e);
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    kind_i = r.kind; operation_i = r.op; bus_select_i = r.bus;
    device_address_i = r.dev; register_address_i = r.regaddr;
    register_two_bytes_i = r.two; transfer_count_i = r.count;
    write_byte_i = r.wbyte; sda_sample_i = r.sda;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [15:0] val);
    drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_index_i = idx; cfg_wdata_i = val;
    if (idx == CFG_HALF_PERIOD) half_ticks = val;
    else ack_limit = val[7:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // junk that an idle controller must ignore: loads land in the buffer
  task automatic idle_noise(int n);
    req_t r;
    repeat (n) begin
      r = any_req();
      if (r.kind == KIND_CMD) begin
        if ($urandom_range(0, 1)) r.op = OP_BAD;
        else r.bus = 4'($urandom_range(NUM_BUSES, 15));
      end
      issue(r);
    end
  endtask

  task automatic run_bus(int nack_pct, int noise_pct);
    req_t r;
    while (ph != PH_IDLE) begin
      r = any_req();
      if ($urandom_range(0, 99) >= noise_pct) begin
        r.kind = KIND_TICK;
        r.sda = in_ack_slot() ? ($urandom_range(0, 99) < nack_pct) : 1'($urandom);
      end
      issue(r);
    end
  endtask

  task automatic transfer(op_e op, logic two, logic [7:0] cnt, int nack_pct, int noise_pct);
    req_t r = any_req();
    bit   ok = 0;
    if (op == OP_WRITE) begin
      while (!ok) begin
        ok = 1;
        for (int i = 0; i < cnt; i++) if (!wbuf_set[i]) ok = 0;
        if (!ok) begin
          r = any_req();
          r.kind = KIND_LOAD;
          issue(r);
        end
      end
    end
    r = any_req();
    r.kind = KIND_CMD; r.op = op; r.two = two; r.count = cnt;
    r.bus = 4'($urandom_range(0, NUM_BUSES - 1));
    issue(r);
    run_bus(nack_pct, noise_pct);
  endtask

  // receiver backpressure: always ready, random, periodic and coin-flip windows
  int rx_cycle = 0;
  always @(negedge clk_i) begin
    rx_cycle++;
    case (rx_cycle[8:7])
      2'd0: out_ready_i = 1'b1;
      2'd1: out_ready_i = ($urandom_range(0, 3) != 0);
      2'd2: out_ready_i = (rx_cycle[2:0] != 3'd5);
      default: out_ready_i = 1'($urandom);
    endcase
  end

  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{clock_line_o, data_line_drive_o, data_line_enable_o, bus_index_o,
              read_data_o, read_valid_o, read_last_o, ack_missing_o,
              device_present_o, busy_res_o, done_res_o};
      if (expected_q.size() == 0) begin
        failed = 1;
        if (mismatches++ < 10) $display("unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          failed = 1;
          if (mismatches++ < 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("[i2c_master_register_transfer] ERROR");
    $finish;
  end

  initial begin
    row_t  rows[$];
    row_t  rw;
    res_t  idle_res;
    req_t  q;
    int    hp_set[2] = '{0, 1};
    int    to_set[2] = '{1, 3};

    half_ticks = HalfPeriodReset; ack_limit = AckTimeoutReset;
    ph = PH_IDLE; bit_cnt = 0; byte_cnt = 0; shreg = 0; ack_wait = 0; load_ptr = 0;
    tick_cnt = 0; act_op = OP_WRITE; act_bus = 0; act_dev = 0; act_reg = 0;
    act_two = 0; act_count = 0; acked = 0; scl = 0; sda = 0; sda_en = 1;
    foreach (wbuf_set[i]) begin
      wbuf_set[i] = 0;
      wbuf[i] = 0;
    end

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    idle_res = '0;
    idle_res.en = 1;
    q = '{KIND_NONE, OP_WRITE, 4'd0, 8'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b0};
    rw.req = q; rw.typed = 1; rw.exp = idle_res;
    rows.push_back(rw);
    rw.req.kind = KIND_TICK; rw.req.sda = 1; rows.push_back(rw);
    rw.req = q; rw.req.kind = KIND_CMD; rw.req.op = OP_BAD; rows.push_back(rw);
    rw.req.op = OP_WRITE; rw.req.bus = 4'd15; rows.push_back(rw);
    rw.req.op = OP_PROBE; rw.req.bus = 4'd10; rows.push_back(rw);
    rw.req = q; rw.req.kind = KIND_LOAD; rw.req.wbyte = 8'h00; rows.push_back(rw);
    rw.req.wbyte = 8'hFF; rows.push_back(rw);
    rw.req.wbyte = 8'hA5; rows.push_back(rw);
    rw.req = '{KIND_CMD, OP_PROBE, 4'd9, 8'hA0, 16'hFFFF, 1'b1, 8'hFF, 8'hFF, 1'b1};
    rw.typed = 0; rows.push_back(rw);
    foreach (rows[i]) issue(rows[i].req, rows[i].typed, rows[i].exp);
    run_bus(0, 0);

    // short bit timing keeps the transfers below brief
    write_reg(CFG_HALF_PERIOD, 16'd1);
    write_reg(CFG_ACK_TIMEOUT, 16'd2);

    // probe with no acknowledge, zero-count and two-byte transfers
    transfer(OP_PROBE, 0, 8'd0, 100, 0);
    transfer(OP_WRITE, 1, 8'd1, 0, 0);
    transfer(OP_WRITE, 0, 8'd0, 20, 0);
    transfer(OP_READ, 1, 8'd1, 0, 0);

    // slowest bit timing: only items that never start a transfer
    write_reg(CFG_HALF_PERIOD, 16'hFFFF);
    write_reg(CFG_ACK_TIMEOUT, 16'd255);
    idle_noise(8);

    for (int s = 0; s < 2; s++) begin
      write_reg(CFG_HALF_PERIOD, 16'(hp_set[s]));
      write_reg(CFG_ACK_TIMEOUT, 16'(to_set[s]));
      idle_noise($urandom_range(0, 3));
      transfer(op_e'($urandom_range(0, 2)), 1'($urandom), 8'($urandom_range(0, 1)),
               $urandom_range(0, 1) ? 10 : 70, 8);
    end

    drain();
    if (!failed && expected_q.size() == 0)
      $display("[i2c_master_register_transfer] OK");
    else
      $display("[i2c_master_register_transfer] ERROR");
    $finish;
  end

endmodule

/* files.f */
rtl/i2cm_pkg.sv
rtl/i2cm_ram.sv
rtl/i2cm_front.sv
rtl/i2cm_back.sv
rtl/i2c_master_register_transfer.sv
verif/i2c_master_register_transfer_test.sv
